/* hw/rtl/v3a_pkg.sv */
// ----------------------------------------------------------------------------
// v3a_pkg
// Types, operation codes and saturation helpers for the vector unit.
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int EXT_BITS  = PROD_BITS + 2;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;

  localparam logic [3:0] FN_ADD   = 4'd0;
  localparam logic [3:0] FN_NEG   = 4'd1;
  localparam logic [3:0] FN_SCALE = 4'd2;
  localparam logic [3:0] FN_DIV   = 4'd3;
  localparam logic [3:0] FN_DOT   = 4'd4;
  localparam logic [3:0] FN_CROSS = 4'd5;
  localparam logic [3:0] FN_LSQ   = 4'd6;
  localparam logic [3:0] FN_LEN   = 4'd7;
  localparam logic [3:0] FN_NORM  = 4'd8;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } in_data_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic [1:0]         status;
  } out_data_t;

  typedef struct packed {
    logic             valid;
    logic [3:0]       func;
    logic [2:0]       aneg;
    logic             sneg;
    word_t [2:0]      mag;
    word_t            dsor;
    word_t [2:0]      r;
    word_t            sc;
    logic             sat;
    logic             dz;
  } tok_t;

  typedef struct packed {
    word_t               rem;
    logic [NUM_BITS-1:0] nq;
  } lane_t;

  typedef struct packed {
    word_t w;
    logic  s;
  } sat_t;

  function automatic logic signed [EXT_BITS-1:0] ext_w(input word_t w);
    return {{(EXT_BITS-WORD_BITS){w[WORD_BITS-1]}}, w};
  endfunction

  function automatic logic signed [EXT_BITS-1:0] ext_p(input logic [PROD_BITS-1:0] p);
    return {{(EXT_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};
  endfunction

  function automatic sat_t sat_word(input logic signed [EXT_BITS-1:0] v);
    logic signed [EXT_BITS-1:0] wmax;
    logic signed [EXT_BITS-1:0] wmin;
    sat_t res;
    wmax = {{(EXT_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    wmin = {{(EXT_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};
    if (v > wmax) begin
      res.w = {1'b0, {(WORD_BITS-1){1'b1}}};
      res.s = 1'b1;
    end else if (v < wmin) begin
      res.w = {1'b1, {(WORD_BITS-1){1'b0}}};
      res.s = 1'b1;
    end else begin
      res.w = v[WORD_BITS-1:0];
      res.s = 1'b0;
    end
    return res;
  endfunction

  function automatic sat_t sat_quot(input logic [NUM_BITS-1:0] q, input logic neg);
    logic [NUM_BITS-1:0] qmax;
    logic [NUM_BITS-1:0] qmin;
    sat_t res;
    qmax = {{(NUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    qmin = {{(NUM_BITS-WORD_BITS){1'b0}}, 1'b1, {(WORD_BITS-1){1'b0}}};
    if (!neg && q > qmax) begin
      res.w = {1'b0, {(WORD_BITS-1){1'b1}}};
      res.s = 1'b1;
    end else if (neg && q > qmin) begin
      res.w = {1'b1, {(WORD_BITS-1){1'b0}}};
      res.s = 1'b1;
    end else begin
      res.w = neg ? (~q[WORD_BITS-1:0]) + 1'b1 : q[WORD_BITS-1:0];
      res.s = 1'b0;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/v3a_front.sv */
// ----------------------------------------------------------------------------
// v3a_front
// Input register, six multipliers, then sums, shifts and saturation for the
// non-dividing operations.
// ----------------------------------------------------------------------------
module v3a_front import v3a_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  in_data_t             in_data,
  output tok_t                 tok_o,
  output logic [PROD_BITS-1:0] acc_o
);

  logic                 v0_r;
  in_data_t             d0_r;
  logic                 v1_r;
  in_data_t             d1_r;
  logic [PROD_BITS-1:0] p_r   [6];
  logic [PROD_BITS-1:0] p_nxt [6];
  word_t                ma    [6];
  word_t                mb    [6];
  tok_t                 tok_r;
  tok_t                 tok_nxt;
  logic [PROD_BITS-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= in_data;
    d1_r <= d0_r;
    for (int i = 0; i < 6; i++) p_r[i] <= p_nxt[i];
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    ma[0] = d0_r.a_x;
    ma[1] = d0_r.a_y;
    ma[2] = d0_r.a_z;
    unique case (d0_r.func)
      FN_SCALE: begin
        mb[0] = d0_r.scalar_in;
        mb[1] = d0_r.scalar_in;
        mb[2] = d0_r.scalar_in;
      end
      FN_DOT: begin
        mb[0] = d0_r.b_x;
        mb[1] = d0_r.b_y;
        mb[2] = d0_r.b_z;
      end
      FN_CROSS: begin
        ma[0] = d0_r.a_y; mb[0] = d0_r.b_z;
        ma[1] = d0_r.a_z; mb[1] = d0_r.b_x;
        ma[2] = d0_r.a_x; mb[2] = d0_r.b_y;
        ma[3] = d0_r.a_z; mb[3] = d0_r.b_y;
        ma[4] = d0_r.a_x; mb[4] = d0_r.b_z;
        ma[5] = d0_r.a_y; mb[5] = d0_r.b_x;
      end
      default: begin
        mb[0] = d0_r.a_x;
        mb[1] = d0_r.a_y;
        mb[2] = d0_r.a_z;
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      p_nxt[i] = $signed({{WORD_BITS{ma[i][WORD_BITS-1]}}, ma[i]})
               * $signed({{WORD_BITS{mb[i][WORD_BITS-1]}}, mb[i]});
    end
  end

  logic signed [EXT_BITS-1:0] e   [6];
  logic signed [EXT_BITS-1:0] sum;
  word_t                      a   [3];
  word_t                      b   [3];
  sat_t                       sv  [3];
  sat_t                       ss;

  always_comb begin
    a[0] = d1_r.a_x; a[1] = d1_r.a_y; a[2] = d1_r.a_z;
    b[0] = d1_r.b_x; b[1] = d1_r.b_y; b[2] = d1_r.b_z;
    for (int i = 0; i < 6; i++) e[i] = ext_p(p_r[i]);
    sum = e[0] + e[1] + e[2];
    for (int i = 0; i < 3; i++) sv[i] = '0;
    ss = '0;
    unique case (d1_r.func)
      FN_ADD:   for (int i = 0; i < 3; i++) sv[i] = sat_word(ext_w(a[i]) + ext_w(b[i]));
      FN_NEG:   for (int i = 0; i < 3; i++) sv[i] = sat_word(-ext_w(a[i]));
      FN_SCALE: for (int i = 0; i < 3; i++) sv[i] = sat_word(e[i] >>> FRAC_BITS);
      FN_CROSS: for (int i = 0; i < 3; i++) sv[i] = sat_word((e[i] - e[i+3]) >>> FRAC_BITS);
      FN_DOT, FN_LSQ: ss = sat_word(sum >>> FRAC_BITS);
      default: ;
    endcase

    tok_nxt.valid = v1_r;
    tok_nxt.func  = d1_r.func;
    tok_nxt.sneg  = d1_r.scalar_in[31];
    tok_nxt.dsor  = d1_r.scalar_in[31] ? word_t'(-d1_r.scalar_in) : word_t'(d1_r.scalar_in);
    for (int i = 0; i < 3; i++) begin
      tok_nxt.aneg[i] = a[i][WORD_BITS-1];
      tok_nxt.mag[i]  = a[i][WORD_BITS-1] ? -a[i] : a[i];
      tok_nxt.r[i]    = sv[i].w;
    end
    tok_nxt.sc  = ss.w;
    tok_nxt.sat = sv[0].s | sv[1].s | sv[2].s | ss.s;
    tok_nxt.dz  = (d1_r.func == FN_DIV) && (d1_r.scalar_in == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    acc_r <= sum[PROD_BITS-1:0];
  end

  assign tok_o = tok_r;
  assign acc_o = acc_r;

endmodule

/* hw/rtl/v3a_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// v3a_sqrt_cell
// One root bit of the integer square root; remainder form, one bit a stage.
// ----------------------------------------------------------------------------
module v3a_sqrt_cell import v3a_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tok_t                 tok_i,
  input  logic [PROD_BITS-1:0] rem_i,
  input  word_t                root_i,
  output tok_t                 tok_o,
  output logic [PROD_BITS-1:0] rem_o,
  output word_t                root_o
);

  logic [PROD_BITS:0]   trial;
  logic [PROD_BITS:0]   diff;
  logic                 take;
  tok_t                 tok_r;
  logic [PROD_BITS-1:0] rem_r;
  word_t                root_r;

  always_comb begin
    trial = ({{(PROD_BITS+1-WORD_BITS){1'b0}}, root_i} << (BIT + 1))
          | ((PROD_BITS+1)'(1) << (2 * BIT));
    diff  = {1'b0, rem_i} - trial;
    take  = !diff[PROD_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_i;
    end
    rem_r  <= take ? diff[PROD_BITS-1:0] : rem_i;
    root_r <= take ? (root_i | (word_t'(1) << BIT)) : root_i;
  end

  assign tok_o  = tok_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

/* hw/rtl/v3a_div_cell.sv */
// ----------------------------------------------------------------------------
// v3a_div_cell
// One quotient bit of restoring division for all three lanes.
// ----------------------------------------------------------------------------
module v3a_div_cell import v3a_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tok_t        tok_i,
  input  word_t       d_i,
  input  lane_t [2:0] lane_i,
  output tok_t        tok_o,
  output word_t       d_o,
  output lane_t [2:0] lane_o
);

  logic [WORD_BITS:0] t    [3];
  logic [WORD_BITS:0] diff [3];
  lane_t [2:0]        lane_nxt;
  tok_t               tok_r;
  word_t              d_r;
  lane_t [2:0]        lane_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]    = {lane_i[i].rem, lane_i[i].nq[NUM_BITS-1]};
      diff[i] = t[i] - {1'b0, d_i};
      lane_nxt[i].rem = !diff[i][WORD_BITS] ? diff[i][WORD_BITS-1:0] : t[i][WORD_BITS-1:0];
      lane_nxt[i].nq  = {lane_i[i].nq[NUM_BITS-2:0], !diff[i][WORD_BITS]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_i;
    end
    d_r    <= d_i;
    lane_r <= lane_nxt;
  end

  assign tok_o  = tok_r;
  assign d_o    = d_r;
  assign lane_o = lane_r;

endmodule

/* hw/rtl/vec3_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// vec3_arithmetic_unit
// Pipelined Q16.16 three-component vector unit: add, negate, scale, divide,
// dot, cross, squared length, length and normalize.
//
//   channel  handshake        payload
//   input    start / busy     in_data  (in_data_t)
//   result   out_valid        out_data (out_data_t)
//
// One transaction per cycle for every operation, through 3 front stages,
// 32 square-root cells, 48 divider cells and an output register.
// busy is held low: the pipeline never stops and results cannot be stalled.
// Synchronous active-low reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module vec3_arithmetic_unit import v3a_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_data_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output out_data_t out_data
);

  localparam int LAT = 4 + WORD_BITS + NUM_BITS;

  tok_t                 sq_tok  [WORD_BITS+1];
  logic [PROD_BITS-1:0] sq_rem  [WORD_BITS+1];
  word_t                sq_root [WORD_BITS+1];
  tok_t                 dv_tok  [NUM_BITS+1];
  word_t                dv_d    [NUM_BITS+1];
  lane_t [2:0]          dv_lane [NUM_BITS+1];
  tok_t                 dv_tok0;
  word_t                dv_d0;
  lane_t [2:0]          dv_lane0;

  assign busy = 1'b0;

  v3a_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .tok_o    (sq_tok[0]),
    .acc_o    (sq_rem[0])
  );
  assign sq_root[0] = '0;

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_sqrt
    v3a_sqrt_cell #(.BIT(WORD_BITS - 1 - k)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (sq_tok[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .tok_o  (sq_tok[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  always_comb begin
    dv_tok0 = sq_tok[WORD_BITS];
    if (sq_tok[WORD_BITS].func == FN_NORM) begin
      dv_d0      = sq_root[WORD_BITS];
      dv_tok0.dz = (sq_root[WORD_BITS] == '0);
    end else if (sq_tok[WORD_BITS].func == FN_LEN) begin
      dv_d0      = sq_tok[WORD_BITS].dsor;
      dv_tok0.sc = sq_root[WORD_BITS][WORD_BITS-1] ? {1'b0, {(WORD_BITS-1){1'b1}}}
                                                    : sq_root[WORD_BITS];
      dv_tok0.sat = sq_root[WORD_BITS][WORD_BITS-1];
    end else begin
      dv_d0 = sq_tok[WORD_BITS].dsor;
    end
    for (int i = 0; i < 3; i++) begin
      dv_lane0[i].rem = '0;
      dv_lane0[i].nq  = {sq_tok[WORD_BITS].mag[i], {FRAC_BITS{1'b0}}};
    end
  end

  assign dv_tok[0]  = dv_tok0;
  assign dv_d[0]    = dv_d0;
  assign dv_lane[0] = dv_lane0;

  for (genvar k = 0; k < NUM_BITS; k++) begin : g_div
    v3a_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_i  (dv_tok[k]),
      .d_i    (dv_d[k]),
      .lane_i (dv_lane[k]),
      .tok_o  (dv_tok[k+1]),
      .d_o    (dv_d[k+1]),
      .lane_o (dv_lane[k+1])
    );
  end

  tok_t      ft;
  sat_t      qs [3];
  word_t     rr [3];
  word_t     rs;
  logic      rsat;
  logic      qdiv;
  out_data_t out_nxt;
  logic      out_valid_r;
  out_data_t out_data_r;

  always_comb begin
    ft   = dv_tok[NUM_BITS];
    qdiv = (ft.func == FN_DIV) || (ft.func == FN_NORM);
    for (int i = 0; i < 3; i++) begin
      qs[i] = sat_quot(dv_lane[NUM_BITS][i].nq,
                       (ft.func == FN_DIV) ? (ft.aneg[i] ^ ft.sneg) : ft.aneg[i]);
      rr[i] = qdiv ? qs[i].w : ft.r[i];
    end
    rs   = qdiv ? '0 : ft.sc;
    rsat = qdiv ? (qs[0].s | qs[1].s | qs[2].s) : ft.sat;
    if (ft.dz) begin
      out_nxt = '0;
      out_nxt.status = ST_DZ;
    end else begin
      out_nxt.r_x        = rr[0];
      out_nxt.r_y        = rr[1];
      out_nxt.r_z        = rr[2];
      out_nxt.scalar_out = rs;
      out_nxt.status     = rsat ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ft.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after fixed latency");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_DZ) |->
      (out_data.r_x == 0 && out_data.r_y == 0 && out_data.r_z == 0 &&
       out_data.scalar_out == 0))
    else $error("divide by zero with nonzero fields");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

endmodule

/* sim/vec3_arithmetic_unit_test.sv */
// ----------------------------------------------------------------------------
// vec3_arithmetic_unit_test
// Self-checking bench for the Q16.16 vector unit: directed corner cases and
// random operations are driven through start/busy, each result is compared
// with a locally computed prediction in arrival order.
// ----------------------------------------------------------------------------
module vec3_arithmetic_unit_test import v3a_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 84;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 1450;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_data_t  in_data;
  logic      busy;
  logic      out_valid;
  out_data_t out_data;

  in_data_t  pending_ops[$];
  out_data_t expected_results[$];
  int        mismatches;
  int        cycles;
  bit        stim_done;
  bit        no_gaps;

  vec3_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic signed [31:0] saturate(input logic signed [127:0] v,
                                                  inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] sqrt_floor(input logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 50; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  // (n << FRAC) / d truncated toward zero
  function automatic logic signed [127:0] fx_div(input logic signed [127:0] n,
                                                 input logic signed [127:0] d);
    logic signed [127:0] num;
    logic signed [127:0] q;
    num = (n < 0 ? -n : n) <<< FRAC_BITS;
    q = num / (d < 0 ? -d : d);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic out_data_t predict_vec_op(input in_data_t op);
    out_data_t res;
    logic signed [127:0] a[3];
    logic signed [127:0] b[3];
    logic signed [127:0] s;
    logic signed [127:0] acc;
    logic signed [127:0] r[3];
    logic [63:0] len;
    bit sat;
    bit dz;
    a[0] = op.a_x; a[1] = op.a_y; a[2] = op.a_z;
    b[0] = op.b_x; b[1] = op.b_y; b[2] = op.b_z;
    s = op.scalar_in;
    sat = 0;
    dz = 0;
    res = '0;
    acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    case (op.func)
      FN_ADD: begin
        res.r_x = saturate(a[0] + b[0], sat);
        res.r_y = saturate(a[1] + b[1], sat);
        res.r_z = saturate(a[2] + b[2], sat);
      end
      FN_NEG: begin
        res.r_x = saturate(-a[0], sat);
        res.r_y = saturate(-a[1], sat);
        res.r_z = saturate(-a[2], sat);
      end
      FN_SCALE: begin
        res.r_x = saturate((a[0] * s) >>> FRAC_BITS, sat);
        res.r_y = saturate((a[1] * s) >>> FRAC_BITS, sat);
        res.r_z = saturate((a[2] * s) >>> FRAC_BITS, sat);
      end
      FN_DIV: begin
        if (s == 0) dz = 1;
        else begin
          res.r_x = saturate(fx_div(a[0], s), sat);
          res.r_y = saturate(fx_div(a[1], s), sat);
          res.r_z = saturate(fx_div(a[2], s), sat);
        end
      end
      FN_DOT: begin
        res.scalar_out = saturate((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC_BITS,
                                  sat);
      end
      FN_CROSS: begin
        r[0] = (a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS;
        r[1] = (a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS;
        r[2] = (a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS;
        res.r_x = saturate(r[0], sat);
        res.r_y = saturate(r[1], sat);
        res.r_z = saturate(r[2], sat);
      end
      FN_LSQ: res.scalar_out = saturate(acc >>> FRAC_BITS, sat);
      FN_LEN: res.scalar_out = saturate($signed({64'd0, sqrt_floor(acc)}), sat);
      FN_NORM: begin
        len = sqrt_floor(acc);
        if (len == 0) dz = 1;
        else begin
          res.r_x = saturate(fx_div(a[0], $signed({64'd0, len})), sat);
          res.r_y = saturate(fx_div(a[1], $signed({64'd0, len})), sat);
          res.r_z = saturate(fx_div(a[2], $signed({64'd0, len})), sat);
        end
      end
      default: ;
    endcase
    if (dz) res = '0;
    res.status = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
    return res;
  endfunction

  function automatic logic [31:0] rand_word(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
      2: return $urandom_range(0, 32'h7ffffff) - 32'h3ffffff;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'h00010000;
          4: return 32'hffffffff;
          default: return 32'hffff0000;
        endcase
      end
    endcase
  endfunction

  task automatic queue_op(input logic [3:0] f, input logic [31:0] ax, input logic [31:0] ay,
                          input logic [31:0] az, input logic [31:0] bx,
                          input logic [31:0] by, input logic [31:0] bz,
                          input logic [31:0] s);
    in_data_t op;
    op.func = f;
    op.a_x = ax; op.a_y = ay; op.a_z = az;
    op.b_x = bx; op.b_y = by; op.b_z = bz;
    op.scalar_in = s;
    pending_ops.push_back(op);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the current transaction
    end else if (pending_ops.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 18)) begin
      start   <= 1'b1;
      in_data <= pending_ops.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) expected_results.push_back(predict_vec_op(in_data));
  end

  // monitor
  always @(posedge clk) begin
    out_data_t want;
    cycles++;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.r_x !== want.r_x) report_mismatch("r_x", out_data.r_x, want.r_x);
        if (out_data.r_y !== want.r_y) report_mismatch("r_y", out_data.r_y, want.r_y);
        if (out_data.r_z !== want.r_z) report_mismatch("r_z", out_data.r_z, want.r_z);
        if (out_data.scalar_out !== want.scalar_out)
          report_mismatch("scalar_out", out_data.scalar_out, want.scalar_out);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int mode;
    logic [3:0] f;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    mismatches = 0;
    cycles = 0;
    no_gaps = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int k = FN_ADD; k <= FN_NORM; k++)
      queue_op(4'(k), 32'h00010000, 32'h00020000, 32'hfffd0000, 32'h00040000,
               32'hffff8000, 32'h00008000, 32'h00020000);
    queue_op(FN_ADD, 32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h0, 32'h0);
    queue_op(FN_NEG, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(FN_SCALE, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0, 32'h0, 32'h0, 32'h80000000);
    queue_op(FN_DIV, 32'h00010000, 32'h2, 32'h3, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(FN_DIV, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h1);
    queue_op(FN_DIV, 32'h80000000, 32'h7, 32'hfffffff9, 32'h0, 32'h0, 32'h0, 32'hffffffff);
    queue_op(FN_DOT, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h80000000, 32'h0);
    queue_op(FN_CROSS, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h0);
    queue_op(FN_LSQ, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(FN_LEN, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(FN_NORM, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(FN_NORM, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(FN_NORM, 32'h80000000, 32'h7fffffff, 32'h1, 32'h0, 32'h0, 32'h0, 32'h0);
    queue_op(4'd9, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1);
    queue_op(4'd15, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
             32'hffffffff, 32'hffffffff);

    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 3);
      f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                       : 4'($urandom_range(FN_ADD, FN_NORM));
      queue_op(f, rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode),
               rand_word(mode), rand_word(mode),
               ($urandom_range(0, 15) == 0) ? 32'h0 : rand_word(mode));
      if (n == 600) begin
        wait (pending_ops.size() == 0);
        no_gaps = 1;
      end
      if (n == 900) begin
        wait (pending_ops.size() == 0);
        no_gaps = 0;
      end
    end
    wait (pending_ops.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
